/* rtl/mmul_pkg.sv */
// ----------------------------------------------------------------------------
// mmul_pkg: shared types and constants for the 256-bit Montgomery multiplier
// Request payloads, the link between round cells, and register indexes.
// ----------------------------------------------------------------------------
package mmul_pkg;

	localparam int unsigned DIGIT_W = 32;
	localparam int unsigned DIGITS  = 8;
	localparam int unsigned OP_W    = DIGIT_W * DIGITS;    // 256
	localparam int unsigned ACC_W   = OP_W + 1;            // accumulator plus carry flag
	localparam int unsigned SUM_W   = OP_W + DIGIT_W + 1;  // 289, before the digit shift
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MOD_WORD0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_WORD1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_WORD2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_WORD3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEG_INV   = 3'd4;

	typedef struct packed {
		logic [63:0] x_word0;
		logic [63:0] x_word1;
		logic [63:0] x_word2;
		logic [63:0] x_word3;
		logic [63:0] y_word0;
		logic [63:0] y_word1;
		logic [63:0] y_word2;
		logic [63:0] y_word3;
	} in_req_t;

	typedef struct packed {
		logic [63:0] r_word0;
		logic [63:0] r_word1;
		logic [63:0] r_word2;
		logic [63:0] r_word3;
	} out_req_t;

	// data handed from one cell to the next
	typedef struct packed {
		logic             valid;
		logic [ACC_W-1:0] acc;
		logic [OP_W-1:0]  x;    // remaining X digits, next one in the low digit
		logic [OP_W-1:0]  y;
	} mmul_link_t;

endpackage

/* rtl/mmul_round_cell.sv */
// ----------------------------------------------------------------------------
// mmul_round_cell: one CIOS round in five stages
// acc' = (acc + x0*Y + q*M) >> 32, q = (acc + x0*Y)[31:0] * ninv mod 2^32.
// ----------------------------------------------------------------------------
module mmul_round_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [mmul_pkg::OP_W-1:0]   m,
	input  logic [mmul_pkg::DIGIT_W-1:0] ninv,
	input  mmul_pkg::mmul_link_t        link_in,
	output mmul_pkg::mmul_link_t        link_out
);

	localparam int unsigned DW = mmul_pkg::DIGIT_W;
	localparam int unsigned ND = mmul_pkg::DIGITS;
	localparam int unsigned OW = mmul_pkg::OP_W;
	localparam int unsigned AW = mmul_pkg::ACC_W;
	localparam int unsigned SW = mmul_pkg::SUM_W;

	logic [2*DW-1:0] pxy_d [ND];
	logic [2*DW-1:0] pxy_s1 [ND];
	logic [AW-1:0]   acc_s1;
	logic [OW-1:0]   x_s1, y_s1;
	logic            v_s1;

	logic [OW-1:0]   lo2, hi2;
	logic [SW-1:0]   sum_s2;
	logic [OW-1:0]   x_s2, y_s2;
	logic            v_s2;

	logic [2*DW-1:0] qfull;
	logic [DW-1:0]   q_s3;
	logic [SW-1:0]   sum_s3;
	logic [OW-1:0]   x_s3, y_s3;
	logic            v_s3;

	logic [2*DW-1:0] pqm_d [ND];
	logic [2*DW-1:0] pqm_s4 [ND];
	logic [SW-1:0]   sum_s4;
	logic [OW-1:0]   x_s4, y_s4;
	logic            v_s4;

	logic [OW-1:0]   lo5, hi5;
	logic [SW-1:0]   sum5;
	logic [AW-1:0]   acc_s5;
	logic [OW-1:0]   x_s5, y_s5;
	logic            v_s5;

	always_comb begin
		for (int j = 0; j < ND; j++) begin
			pxy_d[j] = (2*DW)'(link_in.x[DW-1:0]) * (2*DW)'(link_in.y[DW*j +: DW]);
			pqm_d[j] = (2*DW)'(q_s3) * (2*DW)'(m[DW*j +: DW]);
			lo2[DW*j +: DW] = pxy_s1[j][DW-1:0];
			hi2[DW*j +: DW] = pxy_s1[j][2*DW-1:DW];
			lo5[DW*j +: DW] = pqm_s4[j][DW-1:0];
			hi5[DW*j +: DW] = pqm_s4[j][2*DW-1:DW];
		end
	end

	assign qfull = (2*DW)'(sum_s2[DW-1:0]) * (2*DW)'(ninv);
	assign sum5  = sum_s4 + SW'(lo5) + SW'({hi5, {DW{1'b0}}});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= link_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			pxy_s1 <= pxy_d;
			acc_s1 <= link_in.acc;
			x_s1   <= {{DW{1'b0}}, link_in.x[OW-1:DW]};
			y_s1   <= link_in.y;

			sum_s2 <= SW'(acc_s1) + SW'(lo2) + SW'({hi2, {DW{1'b0}}});
			x_s2   <= x_s1;
			y_s2   <= y_s1;

			q_s3   <= qfull[DW-1:0];
			sum_s3 <= sum_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;

			pqm_s4 <= pqm_d;
			sum_s4 <= sum_s3;
			x_s4   <= x_s3;
			y_s4   <= y_s3;

			acc_s5 <= sum5[SW-1:DW];
			x_s5   <= x_s4;
			y_s5   <= y_s4;
		end
	end

	assign link_out.valid = v_s5;
	assign link_out.acc   = acc_s5;
	assign link_out.x     = x_s5;
	assign link_out.y     = y_s5;

endmodule

/* rtl/mmul_final_cell.sv */
// ----------------------------------------------------------------------------
// mmul_final_cell: conditional subtraction of M and output register
// Subtract when the carry flag is set or the accumulator is at least M.
// ----------------------------------------------------------------------------
module mmul_final_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [mmul_pkg::OP_W-1:0] m,
	input  mmul_pkg::mmul_link_t      link_in,
	output logic                      valid,
	output mmul_pkg::out_req_t        data
);

	localparam int unsigned OW = mmul_pkg::OP_W;

	logic [OW:0]   diff;
	logic          do_sub;
	logic [OW-1:0] r;
	logic [OW-1:0] r_q;
	logic          valid_q;

	assign diff   = {1'b0, link_in.acc[OW-1:0]} - {1'b0, m};
	assign do_sub = link_in.acc[OW] | ~diff[OW];
	assign r      = do_sub ? diff[OW-1:0] : link_in.acc[OW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= link_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= r;
		end
	end

	assign valid        = valid_q;
	assign data.r_word0 = r_q[63:0];
	assign data.r_word1 = r_q[127:64];
	assign data.r_word2 = r_q[191:128];
	assign data.r_word3 = r_q[255:192];

endmodule

/* rtl/montgomery_multiply_256_unit.sv */
// The pipeline is 8 round cells of 5 stages each, then one subtract/output stage.
// Throughput: one request per cycle; the pipeline only halts while a result
//   sits in the output register with out_stall high.
// Reset: arst_n clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
// montgomery_multiply_256_unit: 256-bit Montgomery product X*Y*2^-256 mod M
// Chain of eight CIOS round cells (32-bit digits) plus a final subtract cell.
// ----------------------------------------------------------------------------
module montgomery_multiply_256_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// operand requests
	input  logic                             in_valid,
	output logic                             in_stall,
	input  mmul_pkg::in_req_t                in_data,
	// result requests
	output logic                             out_valid,
	input  logic                             out_stall,
	output mmul_pkg::out_req_t               out_data,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mmul_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                      cfg_data
);

	localparam int unsigned ND = mmul_pkg::DIGITS;
	localparam int unsigned OW = mmul_pkg::OP_W;
	localparam int unsigned DW = mmul_pkg::DIGIT_W;

	// configuration registers; unenforced user rule: written only while unit idle
	logic [63:0]   mod_q [4];
	logic [DW-1:0] ninv_q;
	logic [OW-1:0] m;

	// whole pipeline moves together unless a finished result is held
	logic en;

	mmul_pkg::mmul_link_t link [ND+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q[0] <= '0;
			mod_q[1] <= '0;
			mod_q[2] <= '0;
			mod_q[3] <= '0;
			ninv_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mmul_pkg::REG_MOD_WORD0: mod_q[0] <= cfg_data;
				mmul_pkg::REG_MOD_WORD1: mod_q[1] <= cfg_data;
				mmul_pkg::REG_MOD_WORD2: mod_q[2] <= cfg_data;
				mmul_pkg::REG_MOD_WORD3: mod_q[3] <= cfg_data;
				mmul_pkg::REG_NEG_INV:   ninv_q   <= cfg_data[DW-1:0];
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	assign m = {mod_q[3], mod_q[2], mod_q[1], mod_q[0]};

	assign en       = ~(out_valid & out_stall);
	assign in_stall = ~en;

	// accumulator starts at zero; X digits consumed low first
	assign link[0].valid = in_valid;
	assign link[0].acc   = '0;
	assign link[0].x     = {in_data.x_word3, in_data.x_word2, in_data.x_word1, in_data.x_word0};
	assign link[0].y     = {in_data.y_word3, in_data.y_word2, in_data.y_word1, in_data.y_word0};

	for (genvar i = 0; i < ND; i++) begin : g_round
		mmul_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.m        (m),
			.ninv     (ninv_q),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	// final reduction doubles as the output register
	mmul_final_cell u_final (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.m       (m),
		.link_in (link[ND]),
		.valid   (out_valid),
		.data    (out_data)
	);

endmodule

/* rtl/mmul_checker.sv */
// ----------------------------------------------------------------------------
// mmul_checker: port-level checks for montgomery_multiply_256_unit
// Bound to the top level; watches handshakes and flow control only.
// ----------------------------------------------------------------------------
module mmul_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input mmul_pkg::out_req_t  out_data,
	input logic                cfg_ready
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// input only backs up when a result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	a_drain_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind montgomery_multiply_256_unit mmul_checker u_mmul_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.cfg_ready (cfg_ready)
);

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 256-bit Montgomery multiplier
// Streams operand requests, predicts each product with an independent CIOS
// model, and checks results in order; both sides idle at random but for the last part.
// ----------------------------------------------------------------------------
module tb;

	localparam int LATENCY = 41;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int IDX_W = mmul_pkg::CFG_IDX_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	mmul_pkg::in_req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	mmul_pkg::out_req_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	always #5 clk = ~clk;

	montgomery_multiply_256_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the configuration
	logic [255:0] modulus_q = '0;
	logic [31:0] ninv_q = '0;

	mmul_pkg::out_req_t products_due[$];
	int fail_count = 0;
	bit quiet = 1'b0;       // no idling in the last part of the run
	int in_gap_left = 0;
	int out_stall_left = 0;
	longint cycle_count = 0;

	// CIOS Montgomery product; accumulator kept with its carry bit
	function automatic mmul_pkg::out_req_t mont_product(mmul_pkg::in_req_t req);
		logic [255:0] x, y, acc;
		logic [288:0] sum;
		logic cf;
		logic [31:0] xi, q;
		mmul_pkg::out_req_t res;
		x = {req.x_word3, req.x_word2, req.x_word1, req.x_word0};
		y = {req.y_word3, req.y_word2, req.y_word1, req.y_word0};
		acc = '0;
		cf = 1'b0;
		for (int i = 0; i < 8; i++) begin
			xi = x[32*i +: 32];
			q = (acc[31:0] + xi * y[31:0]) * ninv_q;
			// acc + xi*y + q*M plus carry at digit 8; fits in 289 bits
			sum = {32'd0, acc} + {1'b0, xi} * {1'b0, y} + {1'b0, q} * {1'b0, modulus_q}
				+ ({288'd0, cf} << 256);
			cf = sum[288];
			acc = sum[287:32];
		end
		if (cf || acc >= modulus_q)
			acc = acc - modulus_q;
		res.r_word0 = acc[63:0];
		res.r_word1 = acc[127:64];
		res.r_word2 = acc[191:128];
		res.r_word3 = acc[255:192];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			mmul_pkg::REG_MOD_WORD0: modulus_q[63:0] = val;
			mmul_pkg::REG_MOD_WORD1: modulus_q[127:64] = val;
			mmul_pkg::REG_MOD_WORD2: modulus_q[191:128] = val;
			mmul_pkg::REG_MOD_WORD3: modulus_q[255:192] = val;
			mmul_pkg::REG_NEG_INV: ninv_q = val[31:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every product has arrived and the pipe has drained
	task automatic drain();
		while (products_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// M must be odd for a true inverse; -M^-1 mod 2^32 by Newton iteration
	task automatic load_modulus(input logic [255:0] m, input bit true_inv);
		logic [31:0] inv;
		drain();
		inv = m[31:0];
		for (int k = 0; k < 5; k++) inv = inv * (32'd2 - m[31:0] * inv);
		write_reg(mmul_pkg::REG_MOD_WORD0, m[63:0]);
		write_reg(mmul_pkg::REG_MOD_WORD1, m[127:64]);
		write_reg(mmul_pkg::REG_MOD_WORD2, m[191:128]);
		write_reg(mmul_pkg::REG_MOD_WORD3, m[255:192]);
		write_reg(mmul_pkg::REG_NEG_INV, true_inv ? {32'd0, -inv} : {$urandom, $urandom});
	endtask

	// one operand request; optional random gap first
	task automatic send_operands(input mmul_pkg::in_req_t req);
		if (!quiet && in_gap_left == 0 && $urandom_range(0, 9) == 0)
			in_gap_left = $urandom_range(1, 14);
		while (in_gap_left > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			in_gap_left--;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		products_due.push_back(mont_product(req));
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic logic [255:0] rand256();
		return {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic mmul_pkg::in_req_t pack_ops(logic [255:0] x, logic [255:0] y);
		mmul_pkg::in_req_t r;
		{r.x_word3, r.x_word2, r.x_word1, r.x_word0} = x;
		{r.y_word3, r.y_word2, r.y_word1, r.y_word0} = y;
		return r;
	endfunction

	// operand below m where m is nonzero, else anything
	function automatic logic [255:0] below(logic [255:0] m);
		logic [255:0] v;
		v = rand256();
		if (m != 0) v = v % m;
		return v;
	endfunction

	// result checker and output stall generator
	always @(posedge clk) begin
		mmul_pkg::out_req_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (products_due.size() == 0) begin
				report_mismatch("unexpected result", out_data.r_word0, '0);
			end else begin
				want = products_due.pop_front();
				if (out_data.r_word0 !== want.r_word0)
					report_mismatch("r_word0", out_data.r_word0, want.r_word0);
				if (out_data.r_word1 !== want.r_word1)
					report_mismatch("r_word1", out_data.r_word1, want.r_word1);
				if (out_data.r_word2 !== want.r_word2)
					report_mismatch("r_word2", out_data.r_word2, want.r_word2);
				if (out_data.r_word3 !== want.r_word3)
					report_mismatch("r_word3", out_data.r_word3, want.r_word3);
			end
		end
	end

	always @(negedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (out_stall_left > 0) begin
			out_stall <= 1'b1;
			out_stall_left--;
		end else if ($urandom_range(0, 11) == 0) begin
			out_stall <= 1'b1;
			out_stall_left = $urandom_range(0, 13);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// edge operands on the curve-sized prime field modulus, then on edge and bad moduli
	task automatic test_directed();
		logic [255:0] m;
		m = {64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF,
			64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFE_FFFFFC2F};
		load_modulus(m, 1'b1);
		send_operands(pack_ops('0, '0));
		send_operands(pack_ops(256'd1, 256'd1));
		send_operands(pack_ops(m - 1, m - 1));
		send_operands(pack_ops(m - 1, 256'd1));
		send_operands(pack_ops(256'd0, m - 1));
		// operands at and above M: not fully reduced path
		send_operands(pack_ops(m, m));
		send_operands(pack_ops('1, '1));
		send_operands(pack_ops('1, 256'd0));
		send_operands(pack_ops({8{32'h5555_5555}}, {8{32'hAAAA_AAAA}}));
		idle_input();
		// largest and smallest moduli
		load_modulus('1, 1'b1);
		send_operands(pack_ops('1, '1));
		send_operands(pack_ops('1 - 1, '1 - 2));
		idle_input();
		load_modulus(256'd1, 1'b1);
		send_operands(pack_ops('1, '1));
		send_operands(pack_ops(256'd0, 256'd5));
		idle_input();
		// zero modulus, even modulus, wrong inverse
		load_modulus('0, 1'b1);
		send_operands(pack_ops('1, '1));
		send_operands(pack_ops(rand256(), rand256()));
		idle_input();
		load_modulus(rand256() & ~256'd1, 1'b1);
		send_operands(pack_ops('1, '1));
		send_operands(pack_ops(rand256(), rand256()));
		idle_input();
		load_modulus(rand256() | 256'd1, 1'b0);
		send_operands(pack_ops(rand256(), rand256()));
		send_operands(pack_ops('1, '1));
		idle_input();
	endtask

	// unknown register indexes are ignored
	task automatic test_unknown_index();
		drain();
		for (int i = 5; i < 8; i++) write_reg(IDX_W'(i), {$urandom, $urandom});
		send_operands(pack_ops(rand256(), rand256()));
		idle_input();
	endtask

	// random moduli, mostly odd with a correct inverse and operands below M
	task automatic test_random(input int phases, input int per_phase);
		logic [255:0] m;
		int pick;
		for (int p = 0; p < phases; p++) begin
			pick = $urandom_range(0, 9);
			m = rand256() | 256'd1;
			if (pick == 0) m = m >> $urandom_range(1, 255);
			if (pick == 1) m = m & ~256'd1;
			load_modulus(m, pick != 2);
			for (int k = 0; k < per_phase; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_operands(pack_ops(rand256(), rand256()));
				else
					send_operands(pack_ops(below(m), below(m)));
			end
			idle_input();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_unknown_index();
		test_random(14, 100);
		quiet = 1'b1;
		test_random(2, 100);
		drain();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
